// File: design/zone_point_evaluator_top_macros.svh
// Assertion helpers shared by the evaluator RTL
`ifndef ZONE_POINT_EVALUATOR_TOP_MACROS_SVH
`define ZONE_POINT_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ZPE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("zpe assertion failed");

// Next-cycle implication, disabled during reset
`define ZPE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("zpe assertion failed");

`endif

// File: design/zpe_pkg.sv
package zpe_pkg;

	// default sizing
	localparam int DEF_MAX_ZONES    = 16;
	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_COORD_BITS   = 32;

	localparam logic [15:0] SPEED_LIMIT_RST = 16'hFFFF;

	// opcodes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_BEGIN = 3'd1;
	localparam logic [2:0] OP_ADD   = 3'd2;
	localparam logic [2:0] OP_CLOSE = 3'd3;
	localparam logic [2:0] OP_QUERY = 3'd4;

	// status codes
	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_NO_MATCH = 3'd1;
	localparam logic [2:0] ST_KEEPOUT  = 3'd2;
	localparam logic [2:0] ST_MATCHED  = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	// zone kinds
	localparam logic [1:0] KIND_KEEPOUT = 2'd0;
	localparam logic [1:0] KIND_SPEED   = 2'd1;
	localparam logic [1:0] KIND_LANE    = 2'd2;

	localparam int MIN_POINTS = 3;

	// edge test result
	typedef struct packed {
		logic done;
		logic crosses;
	} edge_res_t;

endpackage

// File: design/zpe_ram.sv
module zpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// File: design/zpe_edge_unit.sv
module zpe_edge_unit #(
	parameter int COORD_BITS = zpe_pkg::DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] xi,
	input  logic signed [COORD_BITS-1:0] yi,
	input  logic signed [COORD_BITS-1:0] xj,
	input  logic signed [COORD_BITS-1:0] yj,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output zpe_pkg::edge_res_t           res
);
	import zpe_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int H = (D + 1) / 2;
	localparam int P = 2 * D;

	typedef enum logic [3:0] {
		E_IDLE = 4'b0001,
		E_MUL  = 4'b0010,
		E_FIN  = 4'b0100,
		E_CMP  = 4'b1000
	} estate_t;

	function automatic logic [D-1:0] mag_of(input logic signed [D-1:0] v);
		mag_of = v[D-1] ? D'(-v) : D'(v);
	endfunction

	function automatic logic [H-1:0] half_of(input logic [D-1:0] m, input logic hi);
		half_of = hi ? H'(m >> H) : m[H-1:0];
	endfunction

	// sign-magnitude less-than
	function automatic logic less_w(input logic an, input logic [P-1:0] am,
			input logic bn, input logic [P-1:0] bm);
		if (an != bn) begin
			less_w = an;
		end else begin
			less_w = an ? (am > bm) : (am < bm);
		end
	endfunction

	estate_t          state_q;
	logic [1:0]       cnt_q;
	logic             pv_q;
	logic [1:0]       sh_q;
	logic [D-1:0]     m_a1_q, m_b1_q, m_a2_q, m_b2_q;
	logic             n1_q, n2_q, dpos_q;
	logic [2*H-1:0]   prod1_q, prod2_q;
	logic [P-1:0]     acc1_q, acc2_q;
	edge_res_t        res_q;

	logic signed [D-1:0] a1, b1, a2, b2;
	logic                straddle;
	logic                l_neg, r_neg, crosses;

	// edge differences and straddle test
	always_comb begin
		a1 = {px[COORD_BITS-1], px} - {xi[COORD_BITS-1], xi};
		b1 = {yj[COORD_BITS-1], yj} - {yi[COORD_BITS-1], yi};
		a2 = {xj[COORD_BITS-1], xj} - {xi[COORD_BITS-1], xi};
		b2 = {py[COORD_BITS-1], py} - {yi[COORD_BITS-1], yi};
		straddle = (yi > py) != (yj > py);
	end

	// final compare of the two cross products
	always_comb begin
		l_neg = n1_q && (acc1_q != '0);
		r_neg = n2_q && (acc2_q != '0);
		crosses = dpos_q ? less_w(l_neg, acc1_q, r_neg, acc2_q)
		                 : less_w(r_neg, acc2_q, l_neg, acc1_q);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			pv_q       <= (state_q == E_MUL);
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						if (straddle) begin
							state_q <= E_MUL;
							cnt_q   <= '0;
						end else begin
							res_q.done    <= 1'b1;
							res_q.crosses <= 1'b0;
						end
					end
				end
				E_MUL: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= E_FIN;
					end
				end
				E_FIN: begin
					state_q <= E_CMP;
				end
				E_CMP: begin
					res_q.done    <= 1'b1;
					res_q.crosses <= crosses;
					state_q       <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// operands, partial products and accumulation
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			m_a1_q <= mag_of(a1);
			m_b1_q <= mag_of(b1);
			m_a2_q <= mag_of(a2);
			m_b2_q <= mag_of(b2);
			n1_q   <= a1[D-1] ^ b1[D-1];
			n2_q   <= a2[D-1] ^ b2[D-1];
			dpos_q <= !b1[D-1];
			acc1_q <= '0;
			acc2_q <= '0;
		end else if (pv_q) begin
			acc1_q <= acc1_q + (P'(prod1_q) << (sh_q * H));
			acc2_q <= acc2_q + (P'(prod2_q) << (sh_q * H));
		end
		prod1_q <= (2*H)'(half_of(m_a1_q, cnt_q[1])) * (2*H)'(half_of(m_b1_q, cnt_q[0]));
		prod2_q <= (2*H)'(half_of(m_a2_q, cnt_q[1])) * (2*H)'(half_of(m_b2_q, cnt_q[0]));
		sh_q    <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
	end

	assign res = res_q;
endmodule

// File: design/zone_point_evaluator_top.sv
// Channel   Handshake          Payload
// input     start / busy       opcode map_id zone_kind zone_enabled zone_speed x_coord y_coord
// result    done (one cycle)   status allowed speed_cap matched_count matched_mask
// config    cfg_we             cfg_wdata (default limit)
//
// For clear, begin, add vertex and close the result is registered and follows in the cycle after acceptance.
// A query walks the zone slots in turn and then finishes. A matching zone first loads its closing
// vertex, then for each vertex reads it from the vertex RAM and tests its edge: an edge that does
// not straddle the query row is settled by the straddle test alone, one that does goes through the
// shared four-step cross-product unit.
// busy stays high during a query. Reset is asynchronous and empties the table; vertex
// storage needs no clearing. The receiver cannot stall results.
`include "zone_point_evaluator_top_macros.svh"

module zone_point_evaluator_top #(
	parameter int MAX_ZONES    = zpe_pkg::DEF_MAX_ZONES,
	parameter int MAX_VERTICES = zpe_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = zpe_pkg::DEF_COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [7:0]         map_id,
	input  logic [1:0]         zone_kind,
	input  logic               zone_enabled,
	input  logic [15:0]        zone_speed,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [2:0]         status,
	output logic               allowed,
	output logic [15:0]        speed_cap,
	output logic [4:0]         matched_count,
	output logic [15:0]        matched_mask
);
	import zpe_pkg::*;

	localparam int ZA = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int ZC = $clog2(MAX_ZONES + 1);
	localparam int VA = $clog2(MAX_VERTICES);
	localparam int VC = $clog2(MAX_VERTICES + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ZONE  = 5'b00010,
		S_PREVW = 5'b00100,
		S_CURW  = 5'b01000,
		S_EDGE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [15:0]   dflt_limit_q;
	logic [ZC-1:0] zone_count_q;
	logic [VC-1:0] vertex_count_q;
	logic          building_q;

	// open zone
	logic [7:0]    open_map_q;
	logic [1:0]    open_kind_q;
	logic          open_on_q;
	logic [15:0]   open_limit_q;
	logic [VC-1:0] open_first_q;
	logic [VC-1:0] open_len_q;

	// committed zones
	logic [7:0]    zmap_q   [MAX_ZONES];
	logic [1:0]    zkind_q  [MAX_ZONES];
	logic          zon_q    [MAX_ZONES];
	logic [15:0]   zlimit_q [MAX_ZONES];
	logic [VC-1:0] zfirst_q [MAX_ZONES];
	logic [VC-1:0] zlen_q   [MAX_ZONES];

	// query context
	logic [ZC-1:0]                zq_q;
	logic [VC-1:0]                vidx_q;
	logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic                         inside_q;
	logic [7:0]                   q_map_q;
	logic [15:0]                  q_limit_q;
	logic                         q_allowed_q;
	logic [4:0]                   q_count_q;
	logic [15:0]                  q_mask_q;

	// result register
	logic        done_q;
	logic [2:0]  status_q;
	logic        allowed_q;
	logic [15:0] speed_q;
	logic [4:0]  count_q;
	logic [15:0] mask_q;

	logic                         accept;
	logic [ZA-1:0]                zsel;
	logic signed [COORD_BITS-1:0] x_in, y_in, rd_x, rd_y;
	logic [VA-1:0]                rd_addr;
	logic                         wr_en;
	logic                         edge_start;
	edge_res_t                    edge_res;
	logic                         new_inside;
	logic [15:0]                  hit_mask;
	logic                         close_ok;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign zsel   = zq_q[ZA-1:0];

	// coordinate wrap or sign extension
	if (COORD_BITS <= 32) begin : g_narrow
		assign x_in = x_coord[COORD_BITS-1:0];
		assign y_in = y_coord[COORD_BITS-1:0];
	end else begin : g_wide
		assign x_in = {{(COORD_BITS-32){x_coord[31]}}, x_coord};
		assign y_in = {{(COORD_BITS-32){y_coord[31]}}, y_coord};
	end

	// vertex RAM read address per state
	always_comb begin
		unique case (state_q)
			S_ZONE:  rd_addr = VA'({1'b0, zfirst_q[zsel]} + {1'b0, zlen_q[zsel]}
			                       - (VC+1)'(1));
			S_PREVW: rd_addr = zfirst_q[zsel][VA-1:0];
			S_EDGE:  rd_addr = VA'({1'b0, zfirst_q[zsel]} + {1'b0, vidx_q} + (VC+1)'(1));
			default: rd_addr = '0;
		endcase
	end

	assign wr_en = accept && (opcode == OP_ADD) && building_q &&
	               (vertex_count_q < VC'(MAX_VERTICES));

	zpe_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_x (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (vertex_count_q[VA-1:0]),
		.wr_data (x_in),
		.rd_addr (rd_addr),
		.rd_data (rd_x)
	);

	zpe_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram_y (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (vertex_count_q[VA-1:0]),
		.wr_data (y_in),
		.rd_addr (rd_addr),
		.rd_data (rd_y)
	);

	assign edge_start = (state_q == S_CURW);

	zpe_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (edge_start),
		.xi     (rd_x),
		.yi     (rd_y),
		.xj     (prev_x_q),
		.yj     (prev_y_q),
		.px     (pt_x_q),
		.py     (pt_y_q),
		.res    (edge_res)
	);

	assign new_inside = inside_q ^ edge_res.crosses;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			hit_mask[k] = (32'(zq_q) == k);
		end
	end

	assign close_ok = (open_len_q >= VC'(MIN_POINTS)) && (open_kind_q <= KIND_LANE) &&
	                  !(open_kind_q == KIND_SPEED && open_limit_q == '0);

	// control and item handling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			dflt_limit_q   <= SPEED_LIMIT_RST;
			zone_count_q   <= '0;
			vertex_count_q <= '0;
			building_q     <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				dflt_limit_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_QUERY) begin
							state_q <= S_ZONE;
						end else begin
							done_q <= 1'b1;
						end
						case (opcode)
							OP_CLEAR: begin
								zone_count_q   <= '0;
								vertex_count_q <= '0;
								building_q     <= 1'b0;
							end
							OP_BEGIN: begin
								if (zone_count_q >= ZC'(MAX_ZONES)) begin
									building_q <= 1'b0;
								end else begin
									building_q <= 1'b1;
									if (building_q) begin
										vertex_count_q <= open_first_q;
									end
								end
							end
							OP_ADD: begin
								if (building_q) begin
									if (vertex_count_q >= VC'(MAX_VERTICES)) begin
										vertex_count_q <= open_first_q;
										building_q     <= 1'b0;
									end else begin
										vertex_count_q <= vertex_count_q + VC'(1);
									end
								end
							end
							OP_CLOSE: begin
								building_q <= 1'b0;
								if (building_q) begin
									if (close_ok) begin
										zone_count_q <= zone_count_q + ZC'(1);
									end else begin
										vertex_count_q <= open_first_q;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_ZONE: begin
					if (zq_q >= zone_count_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (zon_q[zsel] && zmap_q[zsel] == q_map_q) begin
						state_q <= S_PREVW;
					end
				end
				S_PREVW: state_q <= S_CURW;
				S_CURW:  state_q <= S_EDGE;
				S_EDGE: begin
					if (edge_res.done) begin
						if ({1'b0, vidx_q} + (VC+1)'(1) < {1'b0, zlen_q[zsel]}) begin
							state_q <= S_CURW;
						end else begin
							state_q <= S_ZONE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q  <= ST_ACCEPTED;
					allowed_q <= 1'b0;
					speed_q   <= '0;
					count_q   <= '0;
					mask_q    <= '0;
					case (opcode)
						OP_BEGIN: begin
							if (zone_count_q >= ZC'(MAX_ZONES)) begin
								status_q <= ST_FULL;
							end else begin
								open_map_q   <= map_id;
								open_kind_q  <= zone_kind;
								open_on_q    <= zone_enabled;
								open_limit_q <= zone_speed;
								open_first_q <= building_q ? open_first_q : vertex_count_q;
								open_len_q   <= '0;
							end
						end
						OP_ADD: begin
							if (!building_q) begin
								status_q <= ST_INVALID;
							end else if (vertex_count_q >= VC'(MAX_VERTICES)) begin
								status_q <= ST_FULL;
							end else begin
								open_len_q <= open_len_q + VC'(1);
							end
						end
						OP_CLOSE: begin
							if (!building_q || !close_ok) begin
								status_q <= ST_INVALID;
							end else begin
								zmap_q[zone_count_q[ZA-1:0]]   <= open_map_q;
								zkind_q[zone_count_q[ZA-1:0]]  <= open_kind_q;
								zon_q[zone_count_q[ZA-1:0]]    <= open_on_q;
								zlimit_q[zone_count_q[ZA-1:0]] <= open_limit_q;
								zfirst_q[zone_count_q[ZA-1:0]] <= open_first_q;
								zlen_q[zone_count_q[ZA-1:0]]   <= open_len_q;
							end
						end
						OP_QUERY: begin
							pt_x_q      <= x_in;
							pt_y_q      <= y_in;
							q_map_q     <= map_id;
							q_limit_q   <= dflt_limit_q;
							q_allowed_q <= 1'b1;
							q_count_q   <= '0;
							q_mask_q    <= '0;
							zq_q        <= '0;
						end
						default: ;
					endcase
				end
			end
			S_ZONE: begin
				vidx_q   <= '0;
				inside_q <= 1'b0;
				if (zq_q >= zone_count_q) begin
					allowed_q <= q_allowed_q;
					speed_q   <= q_limit_q;
					count_q   <= q_count_q;
					mask_q    <= q_mask_q;
					if (q_count_q == '0) begin
						status_q <= ST_NO_MATCH;
					end else if (!q_allowed_q) begin
						status_q <= ST_KEEPOUT;
					end else begin
						status_q <= ST_MATCHED;
					end
				end else if (!(zon_q[zsel] && zmap_q[zsel] == q_map_q)) begin
					zq_q <= zq_q + ZC'(1);
				end
			end
			S_PREVW: begin
				prev_x_q <= rd_x;
				prev_y_q <= rd_y;
			end
			S_CURW: begin
				cur_x_q <= rd_x;
				cur_y_q <= rd_y;
			end
			S_EDGE: begin
				if (edge_res.done) begin
					inside_q <= new_inside;
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					vidx_q   <= vidx_q + VC'(1);
					if (!({1'b0, vidx_q} + (VC+1)'(1) < {1'b0, zlen_q[zsel]})) begin
						zq_q <= zq_q + ZC'(1);
						if (new_inside) begin
							if (q_count_q != 5'd31) begin
								q_count_q <= q_count_q + 5'd1;
							end
							q_mask_q <= q_mask_q | hit_mask;
							if (zkind_q[zsel] == KIND_KEEPOUT) begin
								q_allowed_q <= 1'b0;
							end else if (zkind_q[zsel] == KIND_SPEED && zlimit_q[zsel] != '0 &&
							             zlimit_q[zsel] < q_limit_q) begin
								q_limit_q <= zlimit_q[zsel];
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign done          = done_q;
	assign status        = status_q;
	assign allowed       = allowed_q;
	assign speed_cap     = speed_q;
	assign matched_count = count_q;
	assign matched_mask  = mask_q;

	// checks
	`ZPE_ASSERT_IMPL(a_vcount_bound, clk, arst_n, 1'b1, vertex_count_q <= VC'(MAX_VERTICES))
	`ZPE_ASSERT_IMPL(a_open_has_slot, clk, arst_n, building_q, zone_count_q < ZC'(MAX_ZONES))
	`ZPE_ASSERT_IMPL(a_edge_done_waited, clk, arst_n, edge_res.done, state_q == S_EDGE)
	`ZPE_ASSERT_IMPL(a_match_nz, clk, arst_n, done_q && status_q == ST_MATCHED, count_q != '0)
	`ZPE_ASSERT_NEXT(a_query_busy, clk, arst_n, accept && opcode == OP_QUERY, busy)
endmodule

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import zpe_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int NZ = 16;
	localparam int NV = 256;

	typedef struct {
		logic [2:0]         op;
		logic [7:0]         map;
		logic [1:0]         kind;
		logic               en;
		logic [15:0]        spd;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} zone_cmd_t;

	typedef struct {
		logic [2:0]  status;
		logic        allowed;
		logic [15:0] limit;
		logic [4:0]  count;
		logic [15:0] mask;
	} zone_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] opcode = '0;
	logic [7:0] map_id = '0;
	logic [1:0] zone_kind = '0;
	logic zone_enabled = 1'b0;
	logic [15:0] zone_speed = '0;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic done;
	logic [2:0] status;
	logic allowed;
	logic [15:0] speed_cap;
	logic [4:0] matched_count;
	logic [15:0] matched_mask;

	zone_point_evaluator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .map_id(map_id), .zone_kind(zone_kind),
		.zone_enabled(zone_enabled), .zone_speed(zone_speed),
		.x_coord(x_coord), .y_coord(y_coord),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .allowed(allowed), .speed_cap(speed_cap),
		.matched_count(matched_count), .matched_mask(matched_mask)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	zone_cmd_t    cmd_q[$];
	zone_answer_t answer_q[$];
	int error_count = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	// shadow copy of the zone table
	logic [15:0] dflt_limit = SPEED_LIMIT_RST;
	logic [7:0]  sh_map[NZ];
	logic [1:0]  sh_kind[NZ];
	logic        sh_on[NZ];
	logic [15:0] sh_limit[NZ];
	int          sh_first[NZ];
	int          sh_len[NZ];
	longint      sh_vx[NV];
	longint      sh_vy[NV];
	int          sh_zones = 0;
	int          sh_verts = 0;
	bit          sh_open = 0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic bit zone_contains(input int z, input longint px, input longint py);
		int n;
		int f;
		int j;
		bit in_zone;
		longint xi, yi, xj, yj;
		logic signed [127:0] a, b, c, e, lhs, rhs;
		bit cr;
		n = sh_len[z];
		f = sh_first[z];
		in_zone = 0;
		if (n < MIN_POINTS || f + n > NV) return 0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = sh_vx[f + i]; yi = sh_vy[f + i];
			xj = sh_vx[f + j]; yj = sh_vy[f + j];
			if ((yi > py) != (yj > py)) begin
				a = px - xi; b = yj - yi;
				c = xj - xi; e = py - yi;
				lhs = a * b;
				rhs = c * e;
				cr = (b > 0) ? (lhs < rhs) : (rhs < lhs);
				if (cr) in_zone = !in_zone;
			end
			j = i;
		end
		return in_zone;
	endfunction

	function automatic void drop_open_zone();
		if (sh_open && sh_zones < NZ) sh_verts = sh_first[sh_zones];
		sh_open = 0;
	endfunction

	// advance the shadow table by one command and give its answer
	function automatic zone_answer_t evaluate_cmd(input zone_cmd_t c);
		zone_answer_t r;
		longint px, py;
		logic [1:0] k;
		bit ok;
		r = '{ST_ACCEPTED, 1'b0, 16'd0, 5'd0, 16'd0};
		px = c.x;
		py = c.y;
		case (c.op)
			OP_CLEAR: begin
				sh_zones = 0; sh_verts = 0; sh_open = 0;
			end
			OP_BEGIN: begin
				drop_open_zone();
				if (sh_zones >= NZ) r.status = ST_FULL;
				else begin
					sh_map[sh_zones] = c.map; sh_kind[sh_zones] = c.kind;
					sh_on[sh_zones] = c.en; sh_limit[sh_zones] = c.spd;
					sh_first[sh_zones] = sh_verts; sh_len[sh_zones] = 0;
					sh_open = 1;
				end
			end
			OP_ADD: begin
				if (!sh_open || sh_zones >= NZ) r.status = ST_INVALID;
				else if (sh_verts >= NV) begin
					drop_open_zone();
					r.status = ST_FULL;
				end else begin
					sh_vx[sh_verts] = px; sh_vy[sh_verts] = py;
					sh_verts++;
					sh_len[sh_zones]++;
				end
			end
			OP_CLOSE: begin
				if (!sh_open || sh_zones >= NZ) begin
					sh_open = 0;
					r.status = ST_INVALID;
				end else begin
					k = sh_kind[sh_zones];
					ok = sh_len[sh_zones] >= MIN_POINTS && k <= KIND_LANE &&
						!(k == KIND_SPEED && sh_limit[sh_zones] == 0);
					if (ok) begin
						sh_zones++;
						sh_open = 0;
					end else begin
						drop_open_zone();
						r.status = ST_INVALID;
					end
				end
			end
			OP_QUERY: begin
				r.allowed = 1'b1;
				r.limit = dflt_limit;
				for (int z = 0; z < sh_zones; z++) begin
					if (sh_on[z] && sh_map[z] == c.map && zone_contains(z, px, py)) begin
						if (r.count < 31) r.count++;
						r.mask[z] = 1'b1;
						if (sh_kind[z] == KIND_KEEPOUT) r.allowed = 1'b0;
						else if (sh_kind[z] == KIND_SPEED && sh_limit[z] > 0 &&
							sh_limit[z] < r.limit) r.limit = sh_limit[z];
					end
				end
				if (r.count == 0) r.status = ST_NO_MATCH;
				else if (!r.allowed) r.status = ST_KEEPOUT;
				else r.status = ST_MATCHED;
			end
			default: ;
		endcase
		return r;
	endfunction

	// driver: one command per transfer
	always @(posedge clk) begin
		bit took;
		zone_cmd_t c;
		took = start && !busy && arst_n;
		if (took) begin
			answer_q.insert(answer_q.size(), evaluate_cmd(cmd_q.pop_front()));
		end
		if (start && !took) begin
		end else if (arst_n && cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
			c = cmd_q[0];
			start <= 1'b1;
			opcode <= c.op; map_id <= c.map; zone_kind <= c.kind;
			zone_enabled <= c.en; zone_speed <= c.spd;
			x_coord <= c.x; y_coord <= c.y;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: compare each result transfer with the oldest answer
	always @(posedge clk) begin
		zone_answer_t w;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				$display("MISMATCH unexpected result at %0t", $realtime);
				error_count++;
			end else begin
				w = answer_q.pop_front();
				if (status !== w.status) report_mismatch("status", status, w.status);
				if (allowed !== w.allowed) report_mismatch("allowed", allowed, w.allowed);
				if (speed_cap !== w.limit) report_mismatch("speed_cap", speed_cap, w.limit);
				if (matched_count !== w.count)
					report_mismatch("matched_count", matched_count, w.count);
				if (matched_mask !== w.mask) report_mismatch("matched_mask", matched_mask, w.mask);
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void push_cmd(input logic [2:0] op, input logic [7:0] m,
		input logic [1:0] k, input logic en, input logic [15:0] s,
		input logic signed [31:0] x, input logic signed [31:0] y);
		zone_cmd_t c;
		c = '{op, m, k, en, s, x, y};
		cmd_q.insert(cmd_q.size(), c);
	endfunction

	function automatic logic signed [31:0] pick_coord();
		if ($urandom_range(7) == 0) return $urandom;
		return $signed($urandom_range(200)) - 100;
	endfunction

	function automatic logic [7:0] pick_map();
		case ($urandom_range(7))
			0: return 8'($urandom);
			1: return 8'hFF;
			2, 3: return 8'd1;
			default: return 8'd0;
		endcase
	endfunction

	// whole zone: begin, vertices, close
	function automatic void push_zone(input int nv, input logic [7:0] m,
		input logic [1:0] k, input logic en, input logic [15:0] s);
		push_cmd(OP_BEGIN, m, k, en, s, $urandom, $urandom);
		for (int i = 0; i < nv; i++)
			push_cmd(OP_ADD, 8'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
				pick_coord(), pick_coord());
		push_cmd(OP_CLOSE, 8'($urandom), 2'($urandom), 1'($urandom), 16'($urandom),
			$urandom, $urandom);
	endfunction

	// about n commands of random mix
	function automatic void push_random(input int n);
		int r;
		int nv;
		logic [15:0] s;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3) push_cmd(OP_CLEAR, 8'($urandom), 2'($urandom), 1'($urandom),
				16'($urandom), $urandom, $urandom);
			else if (r < 30) begin
				s = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom);
				nv = ($urandom_range(19) == 0) ? int'($urandom_range(30, 60))
				                               : int'($urandom_range(2, 7));
				push_zone(nv, pick_map(),
					($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2)),
					$urandom_range(5) != 0, s);
				i += nv + 1;
			end else if (r < 80) push_cmd(OP_QUERY, pick_map(), 2'($urandom), 1'($urandom),
				16'($urandom), pick_coord(), pick_coord());
			else push_cmd(3'($urandom), 8'($urandom), 2'($urandom), 1'($urandom),
				16'($urandom), $urandom, $urandom);
		end
	endfunction

	task automatic drain_and_pause();
		while (cmd_q.size() > 0 || start || answer_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_default_limit(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		dflt_limit = v;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		push_cmd(OP_QUERY, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd1, 32'sd1);
		push_cmd(OP_CLOSE, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		push_cmd(OP_BEGIN, 8'd3, KIND_KEEPOUT, 1'b1, 16'd0, 32'sd0, 32'sd0);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sh8000_0000, 32'sh8000_0000);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		push_cmd(OP_CLOSE, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		push_cmd(OP_QUERY, 8'd3, 2'd0, 1'b0, 16'd0, 32'sd5, 32'sd5);
		push_cmd(OP_QUERY, 8'd3, 2'd0, 1'b0, 16'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		push_zone(3, 8'd3, KIND_SPEED, 1'b1, 16'd0);
		push_cmd(OP_BEGIN, 8'd3, KIND_SPEED, 1'b1, 16'hFFFF, 32'sd0, 32'sd0);
		push_cmd(OP_BEGIN, 8'd3, 2'd3, 1'b1, 16'd100, 32'sd0, 32'sd0);
		push_cmd(OP_ADD, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd1, 32'sd1);
		push_cmd(OP_QUERY, 8'd3, 2'd0, 1'b0, 16'd0, 32'sd5, 32'sd5);
		push_cmd(3'd5, 8'hFF, 2'd3, 1'b1, 16'hFFFF, -32'sd1, -32'sd1);
		push_cmd(3'd7, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		push_cmd(OP_CLEAR, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		// table full, then pool full
		for (int i = 0; i < 17; i++)
			push_zone(3, 8'd0, KIND_LANE, 1'b1, 16'd1);
		push_cmd(OP_CLEAR, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		push_zone(257, 8'd0, KIND_LANE, 1'b1, 16'd1);
		push_cmd(OP_QUERY, 8'd0, 2'd0, 1'b0, 16'd0, 32'sd0, 32'sd0);
		drain_and_pause();

		// random phases, one default limit each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_default_limit(16'hFFFF);
				1: write_default_limit(16'd0);
				2: write_default_limit(16'($urandom));
				default: write_default_limit(16'd1);
			endcase
			idle_pct = (ph == 1) ? 69 : (ph == 3) ? 8 : 0;
			push_random(ph == 2 ? 85 : 100);
			drain_and_pause();
		end

		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/zpe_pkg.sv
design/zpe_ram.sv
design/zpe_edge_unit.sv
design/zone_point_evaluator_top.sv
test/tb_top.sv
